// File: rtl/core/bpce_pkg.sv
package bpce_pkg;

    typedef longint unsigned t_u64;

    // Field widths of the channels.
    localparam int BITS_W     = 63;
    localparam int ORDER_W    = 6;
    localparam int ANGLE_W    = 16;
    localparam int OUT_W      = 24;
    localparam int INV_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS = 2'd1;

    localparam logic [INV_W-1:0] INV_RADIUS_RST = 17'd65536;

    // Fraction bits of the radius reciprocal.
    localparam int INV_FRAC = 16;

    // Powers of z are clamped to +-2^34 and kept in 36 bits.
    localparam int     ZW        = 36;
    localparam int     ZSPLIT    = 18;
    localparam longint POW_LIMIT = 64'sd17179869184;

    // Accumulator: 63 terms of at most 2^34 plus the final power.
    localparam int     SUM_W   = 43;
    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;

    localparam t_u64 HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic load;
        logic look;
        logic smul;
        logic init;
        logic mul;
        logic add;
        logic rnd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic left_zero;
        logic left_one;
        logic out_busy;
    } t_status;

    // Sine of x in [0, pi/2] by an eight-term series, argument and result in Q2.30.
    function automatic t_u64 sin_q30(t_u64 x);
        t_u64   x2;
        t_u64   t;
        longint s;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t  = ((t * x2) >> 30) / 6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 156;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 210;
        s  = s - longint'(t);
        if (s < 0) begin
            s = 0;
        end
        return t_u64'(s);
    endfunction

    // Rounds a Q2.30 value to the given number of fraction bits.
    function automatic t_u64 to_frac(t_u64 q30, int frac);
        int sh;
        sh = 30 - frac;
        return (q30 + (t_u64'(1) << (sh - 1))) >> sh;
    endfunction

endpackage

// File: rtl/core/bpce_if.sv
interface bpce_in_if;
    logic                                valid;
    logic                                ready;
    logic [bpce_pkg::BITS_W-1:0]         bits;
    logic [bpce_pkg::ORDER_W-1:0]        order;
    logic [bpce_pkg::ANGLE_W-1:0]        angle;

    modport source (output valid, output bits, output order, output angle, input ready);
    modport sink   (input valid, input bits, input order, input angle, output ready);
endinterface

interface bpce_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bpce_pkg::OUT_W-1:0]   real_part;
    logic signed [bpce_pkg::OUT_W-1:0]   imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface bpce_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bpce_pkg::CFG_IDX_W-1:0]      index;
    logic [bpce_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bpce_trig_rom.sv
module bpce_trig_rom #(
    parameter int FRAC_BITS        = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]    i_k,
    output logic signed [FRAC_BITS+1:0]            o_cos,
    output logic signed [FRAC_BITS+1:0]            o_sin
);

    // The depth is a multiple of four, so every quadrant reuses the same sine and cosine quarter tables.
    localparam int QDEPTH = SINE_TABLE_DEPTH / 4;
    localparam int KW     = $clog2(SINE_TABLE_DEPTH);
    localparam int MW     = $clog2(QDEPTH);
    localparam int EW     = FRAC_BITS + 1;
    localparam int TW     = FRAC_BITS + 2;

    localparam logic [KW-1:0] Q1_BASE = KW'(QDEPTH);
    localparam logic [KW-1:0] Q2_BASE = KW'(2 * QDEPTH);
    localparam logic [KW-1:0] Q3_BASE = KW'(3 * QDEPTH);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [EW-1:0] tab_sin [QDEPTH];
    logic [EW-1:0] tab_cos [QDEPTH];

    for (genvar g = 0; g < QDEPTH; g++) begin : g_tab
        localparam bpce_pkg::t_u64 PH =
            (bpce_pkg::t_u64'(g) << 32) / SINE_TABLE_DEPTH;
        localparam bpce_pkg::t_u64 TH = (PH * bpce_pkg::HALF_PI_Q30) >> 30;
        assign tab_sin[g] = EW'(bpce_pkg::to_frac(bpce_pkg::sin_q30(TH), FRAC_BITS));
        assign tab_cos[g] = EW'(bpce_pkg::to_frac(
            bpce_pkg::sin_q30(bpce_pkg::HALF_PI_Q30 - TH), FRAC_BITS));
    end

    logic [1:0]              quad;
    logic [KW-1:0]           base;
    logic [KW-1:0]           offset;
    logic [MW-1:0]           m;
    logic signed [TW-1:0]    sv;
    logic signed [TW-1:0]    cv;
    logic signed [TW-1:0]    n_cos;
    logic signed [TW-1:0]    n_sin;
    logic signed [TW-1:0]    r_cos;
    logic signed [TW-1:0]    r_sin;

    always_comb begin
        if (i_k >= Q3_BASE) begin
            quad = QUAD_3;
            base = Q3_BASE;
        end else if (i_k >= Q2_BASE) begin
            quad = QUAD_2;
            base = Q2_BASE;
        end else if (i_k >= Q1_BASE) begin
            quad = QUAD_1;
            base = Q1_BASE;
        end else begin
            quad = QUAD_0;
            base = '0;
        end
        offset = i_k - base;
        m      = offset[MW-1:0];
        sv     = $signed({1'b0, tab_sin[m]});
        cv     = $signed({1'b0, tab_cos[m]});
        case (quad)
            QUAD_0: begin
                n_sin = sv;
                n_cos = cv;
            end
            QUAD_1: begin
                n_sin = cv;
                n_cos = -sv;
            end
            QUAD_2: begin
                n_sin = -sv;
                n_cos = -cv;
            end
            default: begin
                n_sin = -cv;
                n_cos = sv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// File: rtl/core/bpce_dp.sv
module bpce_dp #(
    parameter int MAX_ORDER        = 63,
    parameter int FRAC_BITS        = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bpce_pkg::t_cmd                         i_cmd,
    output bpce_pkg::t_status                      o_status,
    input  logic                                   i_cfg_valid,
    input  logic [bpce_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bpce_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [bpce_pkg::BITS_W-1:0]            i_bits,
    input  logic [bpce_pkg::ORDER_W-1:0]           i_order,
    input  logic [bpce_pkg::ANGLE_W-1:0]           i_angle,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bpce_pkg::OUT_W-1:0]      o_real_part,
    output logic signed [bpce_pkg::OUT_W-1:0]      o_imag_part
);

    localparam int ZW     = bpce_pkg::ZW;
    localparam int ZSPLIT = bpce_pkg::ZSPLIT;
    localparam int SUM_W  = bpce_pkg::SUM_W;
    localparam int OW     = bpce_pkg::ORDER_W;
    localparam int AW     = bpce_pkg::ANGLE_W;
    localparam int KW     = $clog2(SINE_TABLE_DEPTH);
    localparam int DW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KPW    = AW + DW;
    localparam int TW     = FRAC_BITS + 2;
    localparam int SPW    = TW + bpce_pkg::INV_W + 1;
    localparam int LOW_W  = ZSPLIT + 1 + TW;
    localparam int HIGH_W = ZW - ZSPLIT + TW;
    localparam int PW     = ZW + TW + 2;

    localparam logic signed [ZW-1:0]    ONE_Z    = ZW'(longint'(1) << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] ONE_S    = SUM_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [ZW-1:0]    POW_Z    = ZW'(bpce_pkg::POW_LIMIT);
    localparam logic signed [PW-1:0]    POW_P    = PW'(bpce_pkg::POW_LIMIT);
    localparam logic signed [PW-1:0]    HALF_P   = PW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0]    HALF_P_N = HALF_P - PW'(1);
    localparam logic signed [SPW-1:0]   HALF_S   =
        SPW'(longint'(1) << (bpce_pkg::INV_FRAC - 1));
    localparam logic signed [SPW-1:0]   HALF_S_N = HALF_S - SPW'(1);
    localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'(bpce_pkg::OUT_MAX);
    localparam logic signed [SUM_W-1:0] OUT_MIN_S = SUM_W'(bpce_pkg::OUT_MIN);
    localparam logic [OW-1:0]           MAX_ORD   = OW'(MAX_ORDER);

    // Round half away from zero: negative values add one less than half.
    function automatic logic signed [ZW-1:0] round_clamp(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v + (v[PW-1] ? HALF_P_N : HALF_P)) >>> FRAC_BITS;
        if (t > POW_P) begin
            t = POW_P;
        end else if (t < -POW_P) begin
            t = -POW_P;
        end
        return ZW'(t);
    endfunction

    function automatic logic signed [TW-1:0] round_scale(input logic signed [SPW-1:0] v);
        logic signed [SPW-1:0] t;
        t = (v + (v[SPW-1] ? HALF_S_N : HALF_S)) >>> bpce_pkg::INV_FRAC;
        return TW'(t);
    endfunction

    function automatic logic signed [bpce_pkg::OUT_W-1:0] saturate(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] t;
        t = v;
        if (t > OUT_MAX_S) begin
            t = OUT_MAX_S;
        end else if (t < OUT_MIN_S) begin
            t = OUT_MIN_S;
        end
        return bpce_pkg::OUT_W'(t);
    endfunction

    // Configuration and control registers.
    logic                               r_mode;
    logic [bpce_pkg::INV_W-1:0]         r_inv;
    logic [OW-1:0]                      r_left;
    logic                               r_out_valid;

    // Item registers.
    logic [MAX_ORDER-1:0]               r_bits;
    logic [KW-1:0]                      r_k;
    logic signed [TW-1:0]               r_c;
    logic signed [TW-1:0]               r_s;
    logic signed [SPW-1:0]              r_pc;
    logic signed [SPW-1:0]              r_ps;
    logic signed [ZW-1:0]               r_zr;
    logic signed [ZW-1:0]               r_zi;
    logic signed [SUM_W-1:0]            r_sr;
    logic signed [SUM_W-1:0]            r_si;
    logic signed [LOW_W-1:0]            r_lo_rc;
    logic signed [LOW_W-1:0]            r_lo_is;
    logic signed [LOW_W-1:0]            r_lo_rs;
    logic signed [LOW_W-1:0]            r_lo_ic;
    logic signed [HIGH_W-1:0]           r_hi_rc;
    logic signed [HIGH_W-1:0]           r_hi_is;
    logic signed [HIGH_W-1:0]           r_hi_rs;
    logic signed [HIGH_W-1:0]           r_hi_ic;
    logic signed [PW-1:0]               r_pr;
    logic signed [PW-1:0]               r_pi;
    logic signed [bpce_pkg::OUT_W-1:0]  r_real;
    logic signed [bpce_pkg::OUT_W-1:0]  r_imag;

    logic [KPW-1:0]                     kprod;
    logic [OW-1:0]                      order_sat;
    logic signed [TW-1:0]               rom_cos;
    logic signed [TW-1:0]               rom_sin;
    logic signed [PW-1:0]               prod_r;
    logic signed [PW-1:0]               prod_i;
    logic signed [SUM_W-1:0]            zr_ext;
    logic signed [SUM_W-1:0]            zi_ext;
    logic signed [SUM_W-1:0]            fin_r;
    logic signed [SUM_W-1:0]            fin_i;

    bpce_trig_rom #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig_rom (
        .i_clk (i_clk),
        .i_en  (i_cmd.look),
        .i_k   (r_k),
        .o_cos (rom_cos),
        .o_sin (rom_sin)
    );

    assign kprod     = KPW'(i_angle) * KPW'(SINE_TABLE_DEPTH);
    assign order_sat = (i_order > MAX_ORD) ? MAX_ORD : i_order;

    // z = hi * 2^18 + lo, with the low half taken as unsigned.
    assign prod_r = ((PW'(r_hi_rc) - PW'(r_hi_is)) <<< ZSPLIT)
                  + (PW'(r_lo_rc) - PW'(r_lo_is));
    assign prod_i = ((PW'(r_hi_rs) + PW'(r_hi_ic)) <<< ZSPLIT)
                  + (PW'(r_lo_rs) + PW'(r_lo_ic));

    assign zr_ext = SUM_W'(r_zr);
    assign zi_ext = SUM_W'(r_zi);
    assign fin_r  = r_mode ? (r_sr + zr_ext) : r_sr;
    assign fin_i  = r_mode ? (r_si + zi_ext) : r_si;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_inv       <= bpce_pkg::INV_RADIUS_RST;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bpce_pkg::CFG_MODE:       r_mode <= i_cfg_data[0];
                    bpce_pkg::CFG_INV_RADIUS: r_inv  <= i_cfg_data[bpce_pkg::INV_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_left <= order_sat;
            end else if (i_cmd.rnd) begin
                r_left <= r_left - OW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bits <= i_bits[MAX_ORDER-1:0];
            r_k    <= kprod[AW +: KW];
        end
        if (i_cmd.smul) begin
            r_pc <= SPW'(rom_cos) * SPW'($signed({1'b0, r_inv}));
            r_ps <= SPW'(rom_sin) * SPW'($signed({1'b0, r_inv}));
        end
        if (i_cmd.init) begin
            if (r_mode) begin
                r_c  <= round_scale(r_pc);
                r_s  <= round_scale(r_ps);
                r_zr <= ONE_Z;
                r_zi <= '0;
                r_sr <= '0;
                r_si <= '0;
            end else begin
                r_c  <= rom_cos;
                r_s  <= rom_sin;
                r_zr <= ZW'(rom_cos);
                r_zi <= ZW'(rom_sin);
                r_sr <= -ONE_S;
                r_si <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_lo_rc <= $signed({1'b0, r_zr[ZSPLIT-1:0]}) * r_c;
            r_lo_is <= $signed({1'b0, r_zi[ZSPLIT-1:0]}) * r_s;
            r_lo_rs <= $signed({1'b0, r_zr[ZSPLIT-1:0]}) * r_s;
            r_lo_ic <= $signed({1'b0, r_zi[ZSPLIT-1:0]}) * r_c;
            r_hi_rc <= $signed(r_zr[ZW-1:ZSPLIT]) * r_c;
            r_hi_is <= $signed(r_zi[ZW-1:ZSPLIT]) * r_s;
            r_hi_rs <= $signed(r_zr[ZW-1:ZSPLIT]) * r_s;
            r_hi_ic <= $signed(r_zi[ZW-1:ZSPLIT]) * r_c;
        end
        if (i_cmd.add) begin
            r_pr <= prod_r;
            r_pi <= prod_i;
            // The current power enters the sum before it is advanced.
            if (r_bits[0]) begin
                if (r_mode) begin
                    r_sr <= r_sr - zr_ext;
                    r_si <= r_si - zi_ext;
                end else begin
                    r_sr <= r_sr + zr_ext;
                    r_si <= r_si + zi_ext;
                end
            end
        end
        if (i_cmd.rnd) begin
            r_zr   <= round_clamp(r_pr);
            r_zi   <= round_clamp(r_pi);
            r_bits <= r_bits >> 1;
        end
        if (i_cmd.emit) begin
            r_real <= saturate(fin_r);
            r_imag <= saturate(fin_i);
        end
    end

    assign o_status.left_zero = (r_left == '0);
    assign o_status.left_one  = (r_left == OW'(1));
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_real_part = r_real;
    assign o_imag_part = r_imag;

    a_step_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rnd |-> (r_left != '0))
        else $error("power step issued with no coefficient left");

    a_power_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rnd |=> (r_zr <= POW_Z && r_zr >= -POW_Z && r_zi <= POW_Z && r_zi >= -POW_Z))
        else $error("power of z outside its clamp range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_out_valid && !i_out_ready))
        else $error("result register loaded while a result is still held");

endmodule

// File: rtl/core/bpce_ctrl.sv
module bpce_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bpce_pkg::t_status    i_status,
    output bpce_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_SMUL = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_RND  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_SMUL;
            end
            S_SMUL: begin
                o_cmd.smul = 1'b1;
                n_state    = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_status.left_zero ? S_FIN : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = i_status.left_one ? S_FIN : S_MUL;
            end
            S_FIN: begin
                // Wait here only while the previous result is still unclaimed.
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/core/bit_polynomial_circle_evaluator.sv
// Evaluates a polynomial with 0/1 coefficients at one point of a circle.
// Input channel i_in: a transaction carries the coefficient bits, the order
// and the angle (a Q0.16 fraction of a turn). Output channel o_res: one
// transaction per input with the real and imaginary parts in signed Q7.16,
// saturated. Configuration channel i_cfg: index 0 selects the mode (0 unit
// circle, 1 scaled circle), index 1 sets the Q1.16 radius reciprocal; it is
// always ready, and the user must write it only while the block is idle;
// the block itself does not enforce this. An item is accepted only in the
// idle state, and the next one only once the result has been emitted and the
// block is idle again. Each coefficient costs a multiply, an add and a round
// step of one shared complex multiplier on the running power of z.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result waits in the datapath
// until the register is free, and the input stays blocked meanwhile.
// Reset (synchronous, active low) returns to idle, drops any pending result
// and sets mode 0 and a radius reciprocal of 1.0.
module bit_polynomial_circle_evaluator #(
    parameter int MAX_ORDER        = 63,
    parameter int FRAC_BITS        = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bpce_in_if.sink            i_in,
    bpce_out_if.source         o_res,
    bpce_cfg_if.sink           i_cfg
);

    bpce_pkg::t_cmd    cmd;
    bpce_pkg::t_status status;
    logic              in_ready;

    bpce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bpce_dp #(
        .MAX_ORDER        (MAX_ORDER),
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_bits      (i_in.bits),
        .i_order     (i_in.order),
        .i_angle     (i_in.angle),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_real_part (o_res.real_part),
        .o_imag_part (o_res.imag_part)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

endmodule
